/* rtl/timestamp_priority_queue_unit_assert.svh */
// Assertion helpers for the timestamp priority queue.
// Checks are clocked on i_clk and held off while i_rst_n is low.
`ifndef TIMESTAMP_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define TIMESTAMP_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// lbl: assertion label, prop: property expression, msg: message string
`define TPQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

`endif

/* rtl/tpq_pkg.sv */
`timescale 1ns / 1ps

package tpq_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 8;
    localparam int DEFAULT_NODE_COUNT  = 8;

    localparam int STAMP_W  = 32;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

    // memory port strobes from the sequencer
    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

    // per-item result flags from the sequencer
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                is_head;
    } t_res_flags;

endpackage

/* rtl/timestamp_priority_queue_unit.sv */
`timescale 1ns / 1ps
// Sorted priority queue of pending lock requests, keyed by (stamp, node id).
// Input stream (s_axis): one request item per handshake; opcode insert,
// remove by node id, or query. Output stream (m_axis): one result item per
// request with status, head match flag, entry count and the head entry.
// Entries live in a single-port-write, registered-read memory; the slot-zero
// head is shadowed in a register. Each item is taken only while the
// sequencer is idle and is walked through the memory slot by slot:
//   query, full insert, absent-queue remove: straight to the result
//   insert: entries with a larger key move up one slot to make room,
//           then the new entry is written (at once into an empty queue)
//   remove: scan from the head to the match, then the entries above it
//           shift down one slot; a miss scans every entry
// The next item is accepted the cycle after a result loads the output register.
// The result sits in an output register, so the next request is accepted
// while the previous result waits; a stalled receiver holds the sequencer
// at its last step until the output register frees.
// Reset clears the entry count and the control state; the memory is not
// cleared, since only slots below the count are ever read.
`include "timestamp_priority_queue_unit_assert.svh"

module timestamp_priority_queue_unit #(
    parameter int QUEUE_DEPTH = tpq_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int NODE_COUNT  = tpq_pkg::DEFAULT_NODE_COUNT
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // opcode, stamp, node_id (low bit up), zero padded to bytes
    input  logic [((tpq_pkg::OP_W + tpq_pkg::STAMP_W + $clog2(NODE_COUNT) + 7) / 8) * 8 - 1:0]
                 i_s_axis_tdata,
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    // status, is_head, entry_count, head_stamp, head_node (low bit up), zero padded
    output logic [((tpq_pkg::STATUS_W + 1 + $clog2(QUEUE_DEPTH + 1) + tpq_pkg::STAMP_W
                   + $clog2(NODE_COUNT) + 7) / 8) * 8 - 1:0]
                 o_m_axis_tdata
);

    localparam int AW  = $clog2(QUEUE_DEPTH);
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int NW  = $clog2(NODE_COUNT);
    localparam int SW  = tpq_pkg::STAMP_W;
    localparam int OW  = tpq_pkg::OP_W;
    localparam int STW = tpq_pkg::STATUS_W;
    localparam int RW  = STW + 1 + CW + SW + NW;
    localparam int OUTW = ((RW + 7) / 8) * 8;
    localparam logic [CW-1:0] DepthC = CW'(QUEUE_DEPTH);

    logic [OW-1:0] w_op;
    logic [SW-1:0] w_stamp;
    logic [NW-1:0] w_node;

    assign w_op    = i_s_axis_tdata[OW-1:0];
    assign w_stamp = i_s_axis_tdata[OW+SW-1:OW];
    assign w_node  = i_s_axis_tdata[OW+SW+NW-1:OW+SW];

    logic                w_out_free;
    logic                w_done;
    tpq_pkg::t_res_flags w_flags;
    logic [CW-1:0]       w_count;
    logic [SW-1:0]       w_head_stamp;
    logic [NW-1:0]       w_head_node;

    tpq_pkg::t_mem_ctl   w_mem;
    logic [AW-1:0]       w_waddr;
    logic [SW-1:0]       w_wstamp;
    logic [NW-1:0]       w_wnode;
    logic [AW-1:0]       w_raddr;
    logic [SW-1:0]       w_rstamp;
    logic [NW-1:0]       w_rnode;
    logic [SW-1:0]       w_mem_head_stamp;
    logic [NW-1:0]       w_mem_head_node;

    logic                r_out_valid;
    logic [STW-1:0]      r_out_status;
    logic                r_out_is_head;
    logic [CW-1:0]       r_out_count;
    logic [SW-1:0]       r_out_head_stamp;
    logic [NW-1:0]       r_out_head_node;

    assign w_out_free = !r_out_valid || i_m_axis_tready;

    tpq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .NODE_COUNT  (NODE_COUNT)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_s_axis_tvalid),
        .o_in_ready   (o_s_axis_tready),
        .i_op         (w_op),
        .i_stamp      (w_stamp),
        .i_node       (w_node),
        .i_out_free   (w_out_free),
        .o_done       (w_done),
        .o_flags      (w_flags),
        .o_count      (w_count),
        .o_head_stamp (w_head_stamp),
        .o_head_node  (w_head_node),
        .o_mem        (w_mem),
        .o_waddr      (w_waddr),
        .o_wstamp     (w_wstamp),
        .o_wnode      (w_wnode),
        .o_raddr      (w_raddr),
        .i_rstamp     (w_rstamp),
        .i_rnode      (w_rnode),
        .i_head_stamp (w_mem_head_stamp),
        .i_head_node  (w_mem_head_node)
    );

    tpq_mem #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .NODE_COUNT  (NODE_COUNT)
    ) u_mem (
        .i_clk        (i_clk),
        .i_ctl        (w_mem),
        .i_waddr      (w_waddr),
        .i_wstamp     (w_wstamp),
        .i_wnode      (w_wnode),
        .i_raddr      (w_raddr),
        .o_rstamp     (w_rstamp),
        .o_rnode      (w_rnode),
        .o_head_stamp (w_mem_head_stamp),
        .o_head_node  (w_mem_head_node)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out_status     <= w_flags.status;
            r_out_is_head    <= w_flags.is_head;
            r_out_count      <= w_count;
            r_out_head_stamp <= w_head_stamp;
            r_out_head_node  <= w_head_node;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUTW'({r_out_head_node, r_out_head_stamp, r_out_count,
                                    r_out_is_head, r_out_status});

    `TPQ_ASSERT(a_full_at_depth, (r_out_valid && r_out_status == tpq_pkg::STATUS_FULL) |-> (r_out_count == DepthC), "full status with count below depth")
    `TPQ_ASSERT(a_empty_head_zero, (r_out_valid && r_out_count == CW'(0)) |-> (!r_out_is_head && r_out_head_stamp == SW'(0) && r_out_head_node == NW'(0)), "empty queue reports a head")
    `TPQ_ASSERT(a_count_bound, r_out_valid |-> (r_out_count <= DepthC), "entry count above depth")
    `TPQ_ASSERT(a_no_overwrite, w_done |-> (!r_out_valid || i_m_axis_tready), "result loaded over an untaken one")

endmodule

/* rtl/tpq_mem.sv */
`timescale 1ns / 1ps

module tpq_mem #(
    parameter int QUEUE_DEPTH = tpq_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int NODE_COUNT  = tpq_pkg::DEFAULT_NODE_COUNT
) (
    input  logic                        i_clk,
    input  tpq_pkg::t_mem_ctl           i_ctl,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] i_waddr,
    input  logic [tpq_pkg::STAMP_W-1:0] i_wstamp,
    input  logic [$clog2(NODE_COUNT)-1:0] i_wnode,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] i_raddr,
    output logic [tpq_pkg::STAMP_W-1:0] o_rstamp,
    output logic [$clog2(NODE_COUNT)-1:0] o_rnode,
    output logic [tpq_pkg::STAMP_W-1:0] o_head_stamp,
    output logic [$clog2(NODE_COUNT)-1:0] o_head_node
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(NODE_COUNT);
    localparam int SW = tpq_pkg::STAMP_W;

    logic [SW-1:0] mem_stamp [QUEUE_DEPTH];
    logic [NW-1:0] mem_node  [QUEUE_DEPTH];

    logic [SW-1:0] r_rstamp;
    logic [NW-1:0] r_rnode;
    logic [SW-1:0] r_head_stamp;
    logic [NW-1:0] r_head_node;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            mem_stamp[i_waddr] <= i_wstamp;
            mem_node[i_waddr]  <= i_wnode;
        end
        if (i_ctl.re) begin
            r_rstamp <= mem_stamp[i_raddr];
            r_rnode  <= mem_node[i_raddr];
        end
    end

    // shadow copy of slot zero so the head is always at hand
    always_ff @(posedge i_clk) begin
        if (i_ctl.we && i_waddr == AW'(0)) begin
            r_head_stamp <= i_wstamp;
            r_head_node  <= i_wnode;
        end
    end

    assign o_rstamp     = r_rstamp;
    assign o_rnode      = r_rnode;
    assign o_head_stamp = r_head_stamp;
    assign o_head_node  = r_head_node;

endmodule

/* rtl/tpq_ctrl.sv */
`timescale 1ns / 1ps

module tpq_ctrl #(
    parameter int QUEUE_DEPTH = tpq_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int NODE_COUNT  = tpq_pkg::DEFAULT_NODE_COUNT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request side
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [tpq_pkg::OP_W-1:0]         i_op,
    input  logic [tpq_pkg::STAMP_W-1:0]      i_stamp,
    input  logic [$clog2(NODE_COUNT)-1:0]    i_node,
    // result side
    input  logic                             i_out_free,
    output logic                             o_done,
    output tpq_pkg::t_res_flags              o_flags,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] o_count,
    output logic [tpq_pkg::STAMP_W-1:0]      o_head_stamp,
    output logic [$clog2(NODE_COUNT)-1:0]    o_head_node,
    // entry memory
    output tpq_pkg::t_mem_ctl                o_mem,
    output logic [$clog2(QUEUE_DEPTH)-1:0]   o_waddr,
    output logic [tpq_pkg::STAMP_W-1:0]      o_wstamp,
    output logic [$clog2(NODE_COUNT)-1:0]    o_wnode,
    output logic [$clog2(QUEUE_DEPTH)-1:0]   o_raddr,
    input  logic [tpq_pkg::STAMP_W-1:0]      i_rstamp,
    input  logic [$clog2(NODE_COUNT)-1:0]    i_rnode,
    input  logic [tpq_pkg::STAMP_W-1:0]      i_head_stamp,
    input  logic [$clog2(NODE_COUNT)-1:0]    i_head_node
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int NW = $clog2(NODE_COUNT);
    localparam int SW = tpq_pkg::STAMP_W;
    localparam logic [CW-1:0] DepthC = CW'(QUEUE_DEPTH);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_INS    = 6'b000010,
        ST_PUT    = 6'b000100,
        ST_RSCAN  = 6'b001000,
        ST_RSHIFT = 6'b010000,
        ST_DONE   = 6'b100000
    } t_state;

    t_state                       r_state, n_state;
    logic [CW-1:0]                r_count, n_count;
    logic [AW-1:0]                r_pos, n_pos;
    logic [SW-1:0]                r_stamp, n_stamp;
    logic [NW-1:0]                r_node, n_node;
    logic [tpq_pkg::STATUS_W-1:0] r_status, n_status;

    logic          w_key_gt;
    logic [CW-1:0] w_pos_ext;
    logic          w_empty;

    assign w_key_gt  = (i_rstamp > r_stamp) || (i_rstamp == r_stamp && i_rnode > r_node);
    assign w_pos_ext = CW'(r_pos);
    assign w_empty   = (r_count == CW'(0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_stamp  <= n_stamp;
        r_node   <= n_node;
        r_status <= n_status;
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_pos    = r_pos;
        n_stamp  = r_stamp;
        n_node   = r_node;
        n_status = r_status;
        o_mem    = '0;
        o_waddr  = r_pos;
        o_wstamp = r_stamp;
        o_wnode  = r_node;
        o_raddr  = r_pos;
        o_done   = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_stamp  = i_stamp;
                    n_node   = i_node;
                    n_status = tpq_pkg::STATUS_OK;
                    n_state  = ST_DONE;
                    case (i_op)
                        tpq_pkg::OP_INSERT: begin
                            if (r_count == DepthC) begin
                                n_status = tpq_pkg::STATUS_FULL;
                            end else if (w_empty) begin
                                o_mem.we = 1'b1;
                                o_waddr  = '0;
                                o_wstamp = i_stamp;
                                o_wnode  = i_node;
                                n_count  = r_count + CW'(1);
                            end else begin
                                // walk from the tail toward the head
                                o_mem.re = 1'b1;
                                o_raddr  = AW'(r_count - CW'(1));
                                n_pos    = AW'(r_count);
                                n_state  = ST_INS;
                            end
                        end
                        tpq_pkg::OP_REMOVE: begin
                            if (w_empty) begin
                                n_status = tpq_pkg::STATUS_NOT_FOUND;
                            end else begin
                                o_mem.re = 1'b1;
                                o_raddr  = '0;
                                n_pos    = '0;
                                n_state  = ST_RSCAN;
                            end
                        end
                        default: ;  // query and the spare code leave the queue unchanged and just report
                    endcase
                end
            end
            ST_INS: begin
                // read data is the entry just below r_pos
                o_mem.we = 1'b1;
                o_waddr  = r_pos;
                if (w_key_gt) begin
                    o_wstamp = i_rstamp;
                    o_wnode  = i_rnode;
                    n_pos    = r_pos - AW'(1);
                    if (r_pos == AW'(1)) begin
                        n_state = ST_PUT;
                    end else begin
                        o_mem.re = 1'b1;
                        o_raddr  = r_pos - AW'(1) - AW'(1);
                    end
                end else begin
                    n_count = r_count + CW'(1);
                    n_state = ST_DONE;
                end
            end
            ST_PUT: begin
                o_mem.we = 1'b1;
                o_waddr  = r_pos;
                n_count  = r_count + CW'(1);
                n_state  = ST_DONE;
            end
            ST_RSCAN: begin
                if (w_pos_ext + CW'(1) < r_count) begin
                    o_mem.re = 1'b1;
                    o_raddr  = r_pos + AW'(1);
                end
                if (i_rnode == r_node) begin
                    if (w_pos_ext + CW'(1) < r_count) begin
                        n_state = ST_RSHIFT;
                    end else begin
                        n_count = r_count - CW'(1);
                        n_state = ST_DONE;
                    end
                end else if (w_pos_ext + CW'(1) < r_count) begin
                    n_pos = r_pos + AW'(1);
                end else begin
                    n_status = tpq_pkg::STATUS_NOT_FOUND;
                    n_state  = ST_DONE;
                end
            end
            ST_RSHIFT: begin
                // close the gap: entry r_pos+1 moves down to r_pos
                o_mem.we = 1'b1;
                o_waddr  = r_pos;
                o_wstamp = i_rstamp;
                o_wnode  = i_rnode;
                n_pos    = r_pos + AW'(1);
                if (w_pos_ext + CW'(2) < r_count) begin
                    o_mem.re = 1'b1;
                    o_raddr  = r_pos + AW'(1) + AW'(1);
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_in_ready      = (r_state == ST_IDLE);
    assign o_flags.status  = r_status;
    assign o_flags.is_head = !w_empty && i_head_stamp == r_stamp && i_head_node == r_node;
    assign o_count         = r_count;
    assign o_head_stamp    = w_empty ? '0 : i_head_stamp;
    assign o_head_node     = w_empty ? '0 : i_head_node;

endmodule

/* verif/timestamp_priority_queue_unit_checker.sv */
`timescale 1ns / 1ps

module timestamp_priority_queue_unit_checker #(
    parameter int QUEUE_DEPTH = tpq_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int NODE_COUNT  = tpq_pkg::DEFAULT_NODE_COUNT,
    parameter int IN_W        = 40,
    parameter int OUT_W       = 48
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  logic             i_req_ready,
    input  logic [IN_W-1:0]  i_req_data,
    input  logic             i_res_valid,
    input  logic             i_res_ready,
    input  logic [OUT_W-1:0] i_res_data,
    output int               o_mismatches,
    output int               o_outstanding
);

    localparam int NODE_W  = $clog2(NODE_COUNT);
    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int OPW     = tpq_pkg::OP_W;
    localparam int STW     = tpq_pkg::STAMP_W;

    // declared high field first so status lands in the low bits
    typedef struct packed {
        logic [NODE_W-1:0]            head_node;
        logic [STW-1:0]               head_stamp;
        logic [COUNT_W-1:0]           entry_count;
        logic                         is_head;
        logic [tpq_pkg::STATUS_W-1:0] status;
    } t_lock_report;

    logic [STW-1:0]    slot_stamp [QUEUE_DEPTH];
    logic [NODE_W-1:0] slot_node  [QUEUE_DEPTH];
    int                fill = 0;
    t_lock_report      expected_reports [$];
    int                mismatches = 0;

    assign o_mismatches = mismatches;

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t ns: lock queue mismatch: %s", $time, what);
    endtask

    // applies one request to the shadow queue and builds the result it must produce
    task automatic predict_request(input logic [OPW-1:0] op, input logic [STW-1:0] st,
                                   input logic [NODE_W-1:0] nd, output t_lock_report rep);
        int  pos;
        int  k;
        bit  found;
        rep        = '0;
        rep.status = tpq_pkg::STATUS_OK;
        found      = 1'b0;
        pos        = 0;
        if (op == tpq_pkg::OP_INSERT) begin
            if (fill >= QUEUE_DEPTH) begin
                rep.status = tpq_pkg::STATUS_FULL;
            end else begin
                // new entry goes after every entry with a smaller or equal key
                pos = fill;
                while (pos > 0 && (slot_stamp[pos-1] > st ||
                       (slot_stamp[pos-1] == st && slot_node[pos-1] > nd)))
                    pos--;
                for (k = fill; k > pos; k--) begin
                    slot_stamp[k] = slot_stamp[k-1];
                    slot_node[k]  = slot_node[k-1];
                end
                slot_stamp[pos] = st;
                slot_node[pos]  = nd;
                fill++;
            end
        end else if (op == tpq_pkg::OP_REMOVE) begin
            for (k = 0; k < fill; k++) begin
                if (!found && slot_node[k] == nd) begin
                    found = 1'b1;
                    pos   = k;
                end
            end
            if (!found) begin
                rep.status = tpq_pkg::STATUS_NOT_FOUND;
            end else begin
                for (k = pos; k + 1 < fill; k++) begin
                    slot_stamp[k] = slot_stamp[k+1];
                    slot_node[k]  = slot_node[k+1];
                end
                fill--;
            end
        end
        // query and the unused opcode leave the queue alone
        rep.entry_count = COUNT_W'(fill);
        if (fill > 0) begin
            rep.head_stamp = slot_stamp[0];
            rep.head_node  = slot_node[0];
            rep.is_head    = (slot_stamp[0] == st && slot_node[0] == nd);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_lock_report got;
        t_lock_report want;
        if (!i_rst_n) begin
            fill = 0;
            expected_reports.delete();
            o_outstanding <= 0;
        end else begin
            if (i_res_valid && i_res_ready) begin
                got = t_lock_report'(i_res_data[$bits(t_lock_report)-1:0]);
                if (expected_reports.size() == 0) begin
                    report_mismatch($sformatf("result %h with no request pending", got));
                end else begin
                    want = expected_reports.pop_front();
                    if (got.status != want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  got.status, want.status));
                    if (got.is_head != want.is_head)
                        report_mismatch($sformatf("is_head got %0d want %0d",
                                                  got.is_head, want.is_head));
                    if (got.entry_count != want.entry_count)
                        report_mismatch($sformatf("entry_count got %0d want %0d",
                                                  got.entry_count, want.entry_count));
                    if (got.head_stamp != want.head_stamp)
                        report_mismatch($sformatf("head_stamp got %h want %h",
                                                  got.head_stamp, want.head_stamp));
                    if (got.head_node != want.head_node)
                        report_mismatch($sformatf("head_node got %0d want %0d",
                                                  got.head_node, want.head_node));
                end
            end
            if (i_req_valid && i_req_ready) begin
                predict_request(i_req_data[OPW-1:0], i_req_data[OPW +: STW],
                                i_req_data[OPW+STW +: NODE_W], want);
                expected_reports.push_back(want);
            end
            o_outstanding <= expected_reports.size();
        end
    end

endmodule

/* verif/timestamp_priority_queue_unit_test.sv */
`timescale 1ns / 1ps

module timestamp_priority_queue_unit_test;

    localparam int OPW     = tpq_pkg::OP_W;
    localparam int STW     = tpq_pkg::STAMP_W;
    localparam int NODE_W  = $clog2(tpq_pkg::DEFAULT_NODE_COUNT);
    localparam int IN_W    = ((OPW + STW + NODE_W + 7) / 8) * 8;
    localparam int OUT_W   = ((tpq_pkg::STATUS_W + 1 + $clog2(tpq_pkg::DEFAULT_QUEUE_DEPTH + 1)
                              + STW + NODE_W + 7) / 8) * 8;
    localparam logic [OPW-1:0] OP_UNUSED = 2'd3;   // decoded as a query

    localparam int RANDOM_ITEMS = 1880;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 24;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             req_valid = 1'b0;
    logic             req_ready;
    logic [IN_W-1:0]  req_data  = '0;   // opcode, stamp, node_id (low bit up)
    logic             res_valid;
    logic             res_ready = 1'b0;
    logic [OUT_W-1:0] res_data;         // status, is_head, entry_count, head_stamp, head_node

    int mismatches;
    int outstanding;
    int send_idle_pct = 14;
    int recv_idle_pct = 73;
    bit hold_go       = 1'b0;
    int quiet_cycles  = 0;

    logic [STW-1:0]    recent_stamp [8] = '{default: '0};
    logic [NODE_W-1:0] recent_node  [8] = '{default: '0};
    int                recent_wr = 0;

    always #5 clk = ~clk;

    timestamp_priority_queue_unit uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (req_valid),
        .o_s_axis_tready (req_ready),
        .i_s_axis_tdata  (req_data),
        .o_m_axis_tvalid (res_valid),
        .i_m_axis_tready (res_ready),
        .o_m_axis_tdata  (res_data)
    );

    timestamp_priority_queue_unit_checker #(
        .IN_W  (IN_W),
        .OUT_W (OUT_W)
    ) lock_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_req_valid   (req_valid),
        .i_req_ready   (req_ready),
        .i_req_data    (req_data),
        .i_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .i_res_data    (res_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // result side: random back-pressure, plus one long hold-off on request
    initial begin : result_sink
        bit hold_taken;
        hold_taken = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_go && !hold_taken) begin
                hold_taken = 1'b1;
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            res_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((req_valid && req_ready) || (res_valid && res_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("stalled for %0d cycles", quiet_cycles);
                $display("simulation failed");
                $finish;
            end
        end
    end

    // valid stays up across back-to-back items; it only drops for a gap or a drain
    task automatic send_request(input logic [OPW-1:0] op, input logic [STW-1:0] st,
                                input logic [NODE_W-1:0] nd);
        if ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= IN_W'({nd, st, op});
        if (op == tpq_pkg::OP_INSERT) begin
            recent_stamp[recent_wr] = st;
            recent_node[recent_wr]  = nd;
            recent_wr = (recent_wr + 1) % 8;
        end
        do @(posedge clk); while (!req_ready);
    endtask

    task automatic drain_results();
        req_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    initial begin : stimulus
        int                op_roll;
        int                key_roll;
        int                ins_pct;
        int                slot;
        logic [OPW-1:0]    op;
        logic [STW-1:0]    st;
        logic [NODE_W-1:0] nd;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // empty queue: query, unused opcode, remove with nothing stored
        send_request(tpq_pkg::OP_QUERY,  32'd0, 3'd0);
        send_request(OP_UNUSED,          32'd0, 3'd0);
        send_request(tpq_pkg::OP_REMOVE, 32'd0, 3'd5);
        // fill to the top with extremes and duplicate keys
        send_request(tpq_pkg::OP_INSERT, 32'hFFFF_FFFF, 3'd7);
        send_request(tpq_pkg::OP_INSERT, 32'd0, 3'd0);
        send_request(tpq_pkg::OP_INSERT, 32'd0, 3'd0);
        send_request(tpq_pkg::OP_INSERT, 32'd5, 3'd3);
        send_request(tpq_pkg::OP_INSERT, 32'd5, 3'd1);
        send_request(tpq_pkg::OP_INSERT, 32'd5, 3'd3);
        send_request(tpq_pkg::OP_INSERT, 32'hFFFF_FFFF, 3'd0);
        send_request(tpq_pkg::OP_INSERT, 32'd123, 3'd4);
        send_request(tpq_pkg::OP_INSERT, 32'd0, 3'd2);          // full, rejected
        send_request(tpq_pkg::OP_QUERY,  32'd0, 3'd0);
        send_request(tpq_pkg::OP_QUERY,  32'd0, 3'd1);
        send_request(OP_UNUSED,          32'd0, 3'd0);
        send_request(tpq_pkg::OP_REMOVE, 32'd0, 3'd3);
        send_request(tpq_pkg::OP_REMOVE, 32'd0, 3'd6);          // absent id
        send_request(tpq_pkg::OP_REMOVE, 32'd0, 3'd0);
        send_request(tpq_pkg::OP_REMOVE, 32'd0, 3'd0);
        send_request(tpq_pkg::OP_REMOVE, 32'hFFFF_FFFF, 3'd7);
        send_request(tpq_pkg::OP_QUERY,  32'd5, 3'd1);
        send_request(tpq_pkg::OP_INSERT, 32'hAAAA_AAAA, 3'd5);
        send_request(tpq_pkg::OP_INSERT, 32'h5555_5555, 3'd2);
        drain_results();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 3) begin
                send_idle_pct = 73;
                recv_idle_pct = 14;
            end
            if (i == RANDOM_ITEMS / 2)
                drain_results();
            if (i == 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (i == 2 * RANDOM_ITEMS / 3 + 20)
                hold_go = 1'b1;

            // alternate fill-heavy and drain-heavy stretches
            ins_pct = ((i / 60) % 2) ? 30 : 68;
            op_roll = $urandom_range(99);
            if (op_roll < ins_pct)
                op = tpq_pkg::OP_INSERT;
            else if (op_roll < 86)
                op = tpq_pkg::OP_REMOVE;
            else if (op_roll < 97)
                op = tpq_pkg::OP_QUERY;
            else
                op = OP_UNUSED;

            key_roll = $urandom_range(9);
            slot     = $urandom_range(7);
            nd       = NODE_W'($urandom_range(7));
            if (key_roll < 4) begin
                st = $urandom_range(3);
            end else if (key_roll < 7) begin
                // reuse a recently inserted key so head matches and removes hit
                st = recent_stamp[slot];
                nd = recent_node[slot];
            end else if (key_roll == 7) begin
                st = 32'hFFFF_FFFF - $urandom_range(2);
            end else begin
                st = $urandom;
            end
            send_request(op, st, nd);
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (outstanding != 0)
            $display("%0d expected results never arrived", outstanding);
        if (mismatches == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
